// ----- design/dmd_pkg.sv -----
// Shared constants and register codes for the message deframer.
// No dependencies; read first by the interfaces and the top level.
`default_nettype none

package dmd_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int CSR_IDX_W = 8;

   // Message layout, in bytes
   localparam logic [3:0] FIXED_LEN = 4'd10;
   localparam logic [3:0] MULTI_OFS = 4'd6;
   localparam logic [3:0] PLAIN_OFS = 4'd2;
   localparam logic [3:0] FIELD_LEN = 4'd4;

   localparam logic [BYTE_W-1:0] MASK_RST  = 8'd7;
   localparam logic [BYTE_W-1:0] FSET_RST  = 8'd2;
   localparam logic [BYTE_W-1:0] MULTI_RST = 8'd3;
   localparam logic [WORD_W-1:0] LIMIT_RST = 32'd8192;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TYPE_MASK  = 8'd0,
      CSR_FIXED_CODE = 8'd1,
      CSR_MULTI_CODE = 8'd2,
      CSR_SIZE_LIMIT = 8'd3
   } csr_idx_type;

endpackage

`default_nettype wire

// ----- design/dmd_if.sv -----
// Valid/ready channel interfaces of the message deframer: input bytes,
// results and register writes. Depends on dmd_pkg.
`default_nettype none

interface dmd_req_if;
   logic                        valid;
   logic                        ready;
   logic [dmd_pkg::BYTE_W-1:0]  data_byte;
   logic                        end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface dmd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dmd_pkg::WORD_W-1:0]  complete_bytes;
   logic [dmd_pkg::WORD_W-1:0]  total_time;
   logic                        oversize_seen;

   modport source (output valid, output complete_bytes, output total_time,
                   output oversize_seen, input ready);
   modport sink   (input valid, input complete_bytes, input total_time,
                   input oversize_seen, output ready);
endinterface

interface dmd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [dmd_pkg::CSR_IDX_W-1:0]  index;
   logic [dmd_pkg::WORD_W-1:0]     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- design/demo_message_deframer.sv -----
// Message deframer: walks buffer bytes, sums whole messages and time bytes.
// Depends on dmd_pkg and the channel interfaces in dmd_if.sv.
//
//   channel | dir | words              | payload
//   req     | in  | one byte / word    | data_byte, end_of_buffer
//   rsp     | out | one per buffer     | complete_bytes, total_time, oversize_seen
//   csr     | in  | one register write | index, wdata
//
// One byte per cycle while req.ready is high; the per-byte update is a single pass
// from the message state registers into the next state and the result register.
// A result shows on rsp the cycle after its end-marked byte is taken.
// While a result waits and rsp.ready is low, req.ready is low.
// reset restores register defaults and clears all message state; csr is
// always ready.
`default_nettype none

module demo_message_deframer (
   input  wire logic  clock,
   input  wire logic  reset,
   dmd_req_if.sink    req,
   dmd_rsp_if.source  rsp,
   dmd_csr_if.sink    csr
);

   localparam int BW = dmd_pkg::BYTE_W;
   localparam int WW = dmd_pkg::WORD_W;

   // registers
   logic [BW-1:0] mask_ff, fset_ff, multi_ff;
   logic [WW-1:0] limit_ff;
   logic [WW-1:0] pos_ff, pos_in;
   logic [BW-1:0] kind_ff, kind_in;
   logic [BW-1:0] mtime_ff, mtime_in;
   logic [WW-1:0] len_ff, len_in;
   logic [WW-1:0] whole_ff, whole_in;
   logic [WW-1:0] ttot_ff, ttot_in;
   logic          over_ff, over_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0] out_bytes_ff, out_time_ff;
   logic          out_over_ff;

   // per-byte logic
   logic          acc, last, started, is_fixed, is_multi, at_field_end, known, done;
   logic [BW-1:0] b, time_cur, kind_cur;
   logic [3:0]    ofs, field_end;
   logic [WW-1:0] len_cur, pos_next, whole_upd, ttot_upd;
   logic [WW:0]   whole_len, total, time_sum;
   logic [WW+1:0] whole_sum;
   logic          over_upd;

   assign acc  = req.valid && req.ready;
   assign b    = req.data_byte;
   assign last = req.end_of_buffer;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      started  = (pos_ff != '0);
      time_cur = (pos_ff == '0) ? b : mtime_ff;
      kind_cur = (pos_ff == WW'(1)) ? (b & mask_ff) : kind_ff;
      is_fixed = (kind_cur == fset_ff);
      is_multi = (kind_cur == multi_ff);
      ofs       = is_multi ? dmd_pkg::MULTI_OFS : dmd_pkg::PLAIN_OFS;
      field_end = ofs + dmd_pkg::FIELD_LEN - 4'd1;

      len_cur = len_ff;
      for (int k = 0; k < 4; k++) begin
         if (started && !is_fixed && pos_ff == WW'(ofs + 4'(k))) begin
            len_cur[8*k +: 8] = len_ff[8*k +: 8] | b;
         end
      end

      whole_len    = {1'b0, len_cur} + (WW+1)'(ofs + dmd_pkg::FIELD_LEN);
      at_field_end = started && !is_fixed && (pos_ff == WW'(field_end));
      over_upd     = over_ff || (at_field_end && (whole_len > {1'b0, limit_ff}));
      known        = started && (is_fixed || (pos_ff >= WW'(field_end)));
      total        = is_fixed ? (WW+1)'(dmd_pkg::FIXED_LEN) : whole_len;
      pos_next     = (pos_ff == '1) ? pos_ff : pos_ff + WW'(1);
      done         = known && ({1'b0, pos_next} == total);

      whole_sum = (WW+2)'(whole_ff) + (WW+2)'(total);
      time_sum  = (WW+1)'(ttot_ff) + (WW+1)'(time_cur);
      whole_upd = whole_ff;
      ttot_upd  = ttot_ff;
      if (done) begin
         whole_upd = (whole_sum[WW+1:WW] != 2'b00) ? '1 : whole_sum[WW-1:0];
         ttot_upd  = time_sum[WW] ? '1 : time_sum[WW-1:0];
      end

      pos_in   = pos_ff;
      kind_in  = kind_ff;
      mtime_in = mtime_ff;
      len_in   = len_ff;
      whole_in = whole_ff;
      ttot_in  = ttot_ff;
      over_in  = over_ff;
      if (acc) begin
         whole_in = whole_upd;
         ttot_in  = ttot_upd;
         over_in  = over_upd;
         if (done || last) begin
            pos_in   = '0;
            kind_in  = '0;
            mtime_in = '0;
            len_in   = '0;
         end else begin
            pos_in   = pos_next;
            kind_in  = kind_cur;
            mtime_in = time_cur;
            len_in   = len_cur;
         end
         if (last) begin
            whole_in = '0;
            ttot_in  = '0;
            over_in  = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (acc && last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         kind_ff      <= '0;
         mtime_ff     <= '0;
         len_ff       <= '0;
         whole_ff     <= '0;
         ttot_ff      <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         kind_ff      <= kind_in;
         mtime_ff     <= mtime_in;
         len_ff       <= len_in;
         whole_ff     <= whole_in;
         ttot_ff      <= ttot_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && last) begin
         out_bytes_ff <= whole_upd;
         out_time_ff  <= ttot_upd;
         out_over_ff  <= over_upd;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= dmd_pkg::MASK_RST;
         fset_ff  <= dmd_pkg::FSET_RST;
         multi_ff <= dmd_pkg::MULTI_RST;
         limit_ff <= dmd_pkg::LIMIT_RST;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            dmd_pkg::CSR_TYPE_MASK:  mask_ff  <= csr.wdata[BW-1:0];
            dmd_pkg::CSR_FIXED_CODE: fset_ff  <= csr.wdata[BW-1:0];
            dmd_pkg::CSR_MULTI_CODE: multi_ff <= csr.wdata[BW-1:0];
            dmd_pkg::CSR_SIZE_LIMIT: limit_ff <= csr.wdata;
            default: ;
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.complete_bytes = out_bytes_ff;
   assign rsp.total_time     = out_time_ff;
   assign rsp.oversize_seen  = out_over_ff;

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (acc && last) |=> rsp_valid_ff)
      else $error("end-marked byte produced no result");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (acc && last) |=> (pos_ff == '0 && whole_ff == '0 && ttot_ff == '0 && !over_ff))
      else $error("buffer state not cleared after end mark");

   a_over_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(over_ff) |-> ($past(reset) || $past(acc && last)))
      else $error("oversize flag dropped inside a buffer");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("input taken while result stalled");

endmodule

`default_nettype wire
